[rtl/core/gtq_pkg.sv]
// gtq_pkg: request and response types and command and status codes
// of the grouped team queue. Has no dependencies.
`timescale 1ns / 1ps

package gtq_pkg;

   localparam logic [1:0] CMD_ASSIGN  = 2'd0;
   localparam logic [1:0] CMD_ENQUEUE = 2'd1;
   localparam logic [1:0] CMD_DEQUEUE = 2'd2;
   localparam logic [1:0] CMD_CLEAR   = 2'd3;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_DEQUEUED = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam int ELEM_W = 10;

   typedef struct packed {
      logic [1:0]        command;
      logic [ELEM_W-1:0] element;
      logic [7:0]        group;
   } gtq_req_type;

   typedef struct packed {
      logic [ELEM_W-1:0] dequeued_element;
      logic [1:0]        status;
   } gtq_rsp_type;

endpackage

[rtl/core/grouped_team_queue_core.sv]
// grouped_team_queue_core: team queue held in block memories (membership,
// group tail, free stack, node value and node link), run by a sequencer.
// Depends on gtq_pkg.
`timescale 1ns / 1ps

// Usage
// One request channel (req_valid, req_ready, req_data) carries a command
// with an element and a group; one response channel (rsp_valid, rsp_ready,
// rsp_data) returns exactly one response per request, in order.
// One request is worked on at a time. Assign, and dequeue on empty or
// enqueue on full, answer from S_IDLE; dequeue passes S_DEQ1 and S_DEQ2,
// enqueue S_ENQ1 to S_ENQ4, clear the S_CLR sweep before the response.
// The memories have registered reads, and enqueue makes dependent reads
// of the member, group and link memories; clear sweeps the membership,
// group and free memories one address per cycle.
// After reset the same sweep runs with req_ready low and no response.
// The response sits in an output register; a new request is taken when the
// sequencer is idle and that register is empty or being read in the same
// cycle. A stalled receiver holds the response and blocks further requests.
module grouped_team_queue_core
   import gtq_pkg::*;
#(
   parameter int ELEMENT_COUNT = 1024,
   parameter int GROUP_COUNT   = 256,
   parameter int QUEUE_DEPTH   = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  gtq_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output gtq_rsp_type rsp_data
);

   localparam int EW = $clog2(ELEMENT_COUNT);
   localparam int GW = $clog2(GROUP_COUNT);
   localparam int SW = $clog2(QUEUE_DEPTH);
   localparam int OW = $clog2(QUEUE_DEPTH + 1);
   localparam int SWEEP_MAX = (ELEMENT_COUNT > GROUP_COUNT) ?
      ((ELEMENT_COUNT > QUEUE_DEPTH) ? ELEMENT_COUNT : QUEUE_DEPTH) :
      ((GROUP_COUNT > QUEUE_DEPTH) ? GROUP_COUNT : QUEUE_DEPTH);
   localparam int CW = $clog2(SWEEP_MAX);
   localparam logic [OW-1:0] QD_O = OW'(QUEUE_DEPTH);
   localparam logic [CW-1:0] SWEEP_LAST = CW'(SWEEP_MAX - 1);

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_ENQ1 = 8'b0000_0010,
      S_ENQ2 = 8'b0000_0100,
      S_ENQ3 = 8'b0000_1000,
      S_ENQ4 = 8'b0001_0000,
      S_DEQ1 = 8'b0010_0000,
      S_DEQ2 = 8'b0100_0000,
      S_CLR  = 8'b1000_0000
   } state_type;

   // control registers
   state_type   state_ff, state_in;
   logic [OW-1:0] occ_ff, occ_in;
   logic [SW-1:0] head_ff, head_in;
   logic [SW-1:0] tail_ff, tail_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic        clr_rsp_ff, clr_rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // datapath registers
   gtq_rsp_type   rsp_data_ff, rsp_data_in;
   logic [ELEM_W-1:0] elem_ff, elem_in;
   logic          inr_ff, inr_in;
   logic [GW-1:0] grp_ff, grp_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [SW-1:0] t_ff, t_in;
   logic          join_ff, join_in;

   // memories
   logic [GW-1:0]        member_mem [ELEMENT_COUNT];
   logic [SW:0]          group_mem  [GROUP_COUNT];
   logic [SW-1:0]        free_mem   [QUEUE_DEPTH];
   logic [ELEM_W+GW-1:0] node_mem   [QUEUE_DEPTH];
   logic [SW-1:0]        next_mem   [QUEUE_DEPTH];

   logic                 member_we;
   logic [EW-1:0]        member_waddr, member_raddr;
   logic [GW-1:0]        member_wd, member_rd_ff;
   logic                 group_we;
   logic [GW-1:0]        group_waddr, group_raddr;
   logic [SW:0]          group_wd, group_rd_ff;
   logic                 free_we;
   logic [SW-1:0]        free_waddr, free_raddr, free_wd, free_rd_ff;
   logic                 node_we;
   logic [SW-1:0]        node_waddr, node_raddr;
   logic [ELEM_W+GW-1:0] node_wd, node_rd_ff;
   logic                 next_we;
   logic [SW-1:0]        next_waddr, next_raddr, next_wd, next_rd_ff;

   logic          accept;
   logic          req_inr;
   logic          rsp_load;
   gtq_rsp_type   rsp_new;

   always_ff @(posedge clock) begin
      if (member_we) begin
         member_mem[member_waddr] <= member_wd;
      end
      member_rd_ff <= member_mem[member_raddr];
   end

   always_ff @(posedge clock) begin
      if (group_we) begin
         group_mem[group_waddr] <= group_wd;
      end
      group_rd_ff <= group_mem[group_raddr];
   end

   always_ff @(posedge clock) begin
      if (free_we) begin
         free_mem[free_waddr] <= free_wd;
      end
      free_rd_ff <= free_mem[free_raddr];
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_waddr] <= node_wd;
      end
      node_rd_ff <= node_mem[node_raddr];
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_waddr] <= next_wd;
      end
      next_rd_ff <= next_mem[next_raddr];
   end

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign req_inr   = 32'(req_data.element) < ELEMENT_COUNT;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in   = state_ff;
      occ_in     = occ_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      cnt_in     = cnt_ff;
      clr_rsp_in = clr_rsp_ff;
      elem_in    = elem_ff;
      inr_in     = inr_ff;
      grp_in     = grp_ff;
      slot_in    = slot_ff;
      t_in       = t_ff;
      join_in    = join_ff;

      rsp_load = 1'b0;
      rsp_new  = '{dequeued_element: '0, status: ST_DONE};

      member_we    = 1'b0;
      member_waddr = '0;
      member_wd    = '0;
      member_raddr = '0;
      group_we     = 1'b0;
      group_waddr  = '0;
      group_wd     = '0;
      group_raddr  = '0;
      free_we      = 1'b0;
      free_waddr   = '0;
      free_wd      = '0;
      free_raddr   = '0;
      node_we      = 1'b0;
      node_waddr   = '0;
      node_wd      = '0;
      node_raddr   = '0;
      next_we      = 1'b0;
      next_waddr   = '0;
      next_wd      = '0;
      next_raddr   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               elem_in = req_data.element;
               inr_in  = req_inr;
               unique case (req_data.command)
                  CMD_ASSIGN: begin
                     member_we    = req_inr;
                     member_waddr = EW'(req_data.element);
                     member_wd    = (32'(req_data.group) < GROUP_COUNT) ?
                                    GW'(req_data.group) : '0;
                     rsp_load     = 1'b1;
                  end
                  CMD_ENQUEUE: begin
                     if (occ_ff == QD_O) begin
                        rsp_load       = 1'b1;
                        rsp_new.status = ST_FULL;
                     end else begin
                        member_raddr = EW'(req_data.element);
                        free_raddr   = SW'(QD_O - occ_ff - 1'b1);
                        state_in     = S_ENQ1;
                     end
                  end
                  CMD_DEQUEUE: begin
                     if (occ_ff == '0) begin
                        rsp_load       = 1'b1;
                        rsp_new.status = ST_EMPTY;
                     end else begin
                        node_raddr = head_ff;
                        next_raddr = head_ff;
                        state_in   = S_DEQ1;
                     end
                  end
                  CMD_CLEAR: begin
                     cnt_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = S_CLR;
                  end
                  default: ;
               endcase
            end
         end
         S_ENQ1: begin
            grp_in      = inr_ff ? member_rd_ff : '0;
            slot_in     = free_rd_ff;
            group_raddr = inr_ff ? member_rd_ff : '0;
            state_in    = S_ENQ2;
         end
         S_ENQ2: begin
            join_in    = (occ_ff != '0) && (grp_ff != '0) && group_rd_ff[SW];
            t_in       = group_rd_ff[SW-1:0];
            next_raddr = group_rd_ff[SW-1:0];
            node_we    = 1'b1;
            node_waddr = slot_ff;
            node_wd    = {elem_ff, grp_ff};
            if (grp_ff != '0) begin
               group_we    = 1'b1;
               group_waddr = grp_ff;
               group_wd    = {1'b1, slot_ff};
            end
            state_in = S_ENQ3;
         end
         S_ENQ3: begin
            next_we    = 1'b1;
            next_waddr = slot_ff;
            next_wd    = join_ff ? next_rd_ff : '0;
            state_in   = S_ENQ4;
         end
         S_ENQ4: begin
            if (occ_ff == '0) begin
               head_in = slot_ff;
               tail_in = slot_ff;
            end else begin
               next_we    = 1'b1;
               next_waddr = join_ff ? t_ff : tail_ff;
               next_wd    = slot_ff;
               if (!join_ff || (t_ff == tail_ff)) begin
                  tail_in = slot_ff;
               end
            end
            occ_in   = occ_ff + 1'b1;
            rsp_load = 1'b1;
            state_in = S_IDLE;
         end
         S_DEQ1: begin
            elem_in     = node_rd_ff[ELEM_W+GW-1:GW];
            grp_in      = node_rd_ff[GW-1:0];
            slot_in     = next_rd_ff;
            group_raddr = node_rd_ff[GW-1:0];
            free_we     = 1'b1;
            free_waddr  = SW'(QD_O - occ_ff);
            free_wd     = head_ff;
            state_in    = S_DEQ2;
         end
         S_DEQ2: begin
            if ((grp_ff != '0) && group_rd_ff[SW] &&
                (group_rd_ff[SW-1:0] == head_ff)) begin
               group_we    = 1'b1;
               group_waddr = grp_ff;
               group_wd    = {1'b0, group_rd_ff[SW-1:0]};
            end
            occ_in = occ_ff - 1'b1;
            if (occ_ff == OW'(1)) begin
               head_in = '0;
               tail_in = '0;
            end else begin
               head_in = slot_ff;
            end
            rsp_load                 = 1'b1;
            rsp_new.status           = ST_DEQUEUED;
            rsp_new.dequeued_element = elem_ff;
            state_in                 = S_IDLE;
         end
         S_CLR: begin
            member_we    = 32'(cnt_ff) < ELEMENT_COUNT;
            member_waddr = EW'(cnt_ff);
            group_we     = 32'(cnt_ff) < GROUP_COUNT;
            group_waddr  = GW'(cnt_ff);
            free_we      = 32'(cnt_ff) < QUEUE_DEPTH;
            free_waddr   = SW'(cnt_ff);
            free_wd      = SW'(cnt_ff);
            if (cnt_ff == SWEEP_LAST) begin
               occ_in     = '0;
               head_in    = '0;
               tail_in    = '0;
               rsp_load   = clr_rsp_ff;
               clr_rsp_in = 1'b0;
               state_in   = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
      rsp_data_in  = rsp_load ? rsp_new : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         occ_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         cnt_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cnt_ff       <= cnt_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      elem_ff     <= elem_in;
      inr_ff      <= inr_in;
      grp_ff      <= grp_in;
      slot_ff     <= slot_in;
      t_ff        <= t_in;
      join_ff     <= join_in;
   end

endmodule
